[src/page_packed_framebuffer_fill_core_defines.svh]
// Assertion macros for the page packed frame buffer fill core.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef PAGE_PACKED_FRAMEBUFFER_FILL_CORE_DEFINES_SVH
`define PAGE_PACKED_FRAMEBUFFER_FILL_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PPFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define PPFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppfb_pkg.sv]
// Package for the page packed frame buffer fill core.
// Holds display geometry, field widths, command codes and control structs.
`default_nettype none

package ppfb_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  localparam int CMD_W   = 2;
  localparam int POS_W   = 8;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 8;
  localparam int COORD_W = POS_W + 1;
  localparam int PAGE_W  = POS_W - 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic take;
    logic setup;
    logic clr_step;
    logic walk_step;
    logic rd_issue;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic             req_valid;
    logic [CMD_W-1:0] cmd;
    logic             walk_empty;
    logic             walk_last;
    logic             clr_last;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/ppfb_ifs.sv]
// Handshake channels of the frame buffer core: command words in, result words out.
// Depends on ppfb_pkg for field widths.
`default_nettype none

interface ppfb_req_if;
  import ppfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  x_pos;
  logic [POS_W-1:0]  y_pos;
  logic [POS_W-1:0]  rect_width;
  logic [POS_W-1:0]  rect_height;
  logic              pixel_on;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, cmd, x_pos, y_pos, rect_width, rect_height, pixel_on,
                  read_index, input ready);
  modport sink (input valid, cmd, x_pos, y_pos, rect_width, rect_height, pixel_on,
                read_index, output ready);
endinterface

interface ppfb_rsp_if;
  import ppfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              start_outside;

  modport source (output valid, read_data, start_outside, input ready);
  modport sink (input valid, read_data, start_outside, output ready);
endinterface

`default_nettype wire

[src/ppfb_ctl.sv]
// Controller state machine of the frame buffer core.
// Depends on ppfb_pkg; drives the datapath by command struct, reads its status.
`default_nettype none

module ppfb_ctl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ppfb_pkg::dp_stat_t stat,
  output ppfb_pkg::ctl_cmd_t      cmd
);
  import ppfb_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       report;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      report <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take && stat.req_valid) begin
        report <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = report ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.req_valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        unique case (stat.cmd)
          CMD_CLEAR: state_next = S_CLEAR;
          CMD_READ: begin
            cmd.rd_issue = 1'b1;
            state_next   = S_FINISH;
          end
          default: state_next = stat.walk_empty ? S_FINISH : S_WALK;
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/ppfb_dp.sv]
// Datapath of the frame buffer core: command registers, byte walker, frame memory
// and result register. Depends on ppfb_pkg and the channel interfaces.
`default_nettype none

module ppfb_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ppfb_pkg::ctl_cmd_t cmd,
  output ppfb_pkg::dp_stat_t      stat,
  ppfb_req_if.sink                req,
  ppfb_rsp_if.source              rsp
);
  import ppfb_pkg::*;

  logic [DATA_W-1:0]  mem [STORE_BYTES];
  logic [DATA_W-1:0]  mem_q;

  logic [CMD_W-1:0]   cmd_r;
  logic [POS_W-1:0]   x_r;
  logic [POS_W-1:0]   y_r;
  logic               on_r;
  logic [IDX_W-1:0]   idx_r;
  logic               outside_r;
  logic [COORD_W-1:0] xe_r;
  logic [COORD_W-1:0] ye_r;

  logic [PAGE_W-1:0]  page_r;
  logic [PAGE_W-1:0]  pfirst_r;
  logic [PAGE_W-1:0]  plast_r;
  logic [2:0]         ylo_r;
  logic [2:0]         yhi_r;
  logic [POS_W-1:0]   col_r;
  logic [ADDR_W-1:0]  base_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  clr_cnt;

  logic               pend_v;
  logic [ADDR_W-1:0]  pend_addr;
  logic [DATA_W-1:0]  pend_mask;
  logic               pend_on;

  logic               load;
  logic [POS_W-1:0]   w_eff;
  logic [POS_W-1:0]   h_eff;
  logic [COORD_W-1:0] xsum;
  logic [COORD_W-1:0] ysum;
  logic               outside_in;
  logic [COORD_W-1:0] ylast;
  logic [PAGE_W-1:0]  page_first;
  logic [ADDR_W-1:0]  base_first;
  logic               col_last;
  logic [2:0]         lo;
  logic [2:0]         hi;
  logic [DATA_W-1:0]  mask;
  logic               idx_ok;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  assign req.ready = cmd.take;
  assign load      = cmd.take && req.valid;

  always_comb begin
    if (req.cmd == CMD_PIXEL) begin
      w_eff = POS_W'(1);
      h_eff = POS_W'(1);
    end else begin
      w_eff = req.rect_width;
      h_eff = req.rect_height;
    end
    xsum = COORD_W'(req.x_pos) + COORD_W'(w_eff);
    ysum = COORD_W'(req.y_pos) + COORD_W'(h_eff);
    outside_in = ((req.cmd == CMD_PIXEL) || (req.cmd == CMD_FILL)) &&
                 ((COORD_W'(req.x_pos) >= COORD_W'(DISPLAY_WIDTH)) ||
                  (COORD_W'(req.y_pos) >= COORD_W'(DISPLAY_HEIGHT)));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r     <= req.cmd;
      x_r       <= req.x_pos;
      y_r       <= req.y_pos;
      on_r      <= req.pixel_on;
      idx_r     <= req.read_index;
      outside_r <= outside_in;
      xe_r      <= (xsum > COORD_W'(DISPLAY_WIDTH)) ? COORD_W'(DISPLAY_WIDTH) : xsum;
      ye_r      <= (ysum > COORD_W'(DISPLAY_HEIGHT)) ? COORD_W'(DISPLAY_HEIGHT) : ysum;
    end
  end

  assign ylast      = ye_r - COORD_W'(1);
  assign page_first = y_r[POS_W-1:3];
  assign base_first = ADDR_W'(int'(page_first) * DISPLAY_WIDTH);
  assign col_last   = (COORD_W'(col_r) + COORD_W'(1)) == xe_r;

  always_comb begin
    lo   = (page_r == pfirst_r) ? ylo_r : 3'd0;
    hi   = (page_r == plast_r) ? yhi_r : 3'd7;
    mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      page_r   <= page_first;
      pfirst_r <= page_first;
      plast_r  <= ylast[POS_W-1:3];
      ylo_r    <= y_r[2:0];
      yhi_r    <= ylast[2:0];
      col_r    <= x_r;
      base_r   <= base_first;
      addr_r   <= base_first + ADDR_W'(x_r);
    end else if (cmd.walk_step) begin
      if (col_last) begin
        page_r <= page_r + PAGE_W'(1);
        col_r  <= x_r;
        base_r <= base_r + ADDR_W'(DISPLAY_WIDTH);
        addr_r <= base_r + ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(x_r);
      end else begin
        col_r  <= col_r + POS_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v  <= 1'b0;
      clr_cnt <= '0;
    end else begin
      pend_v <= cmd.walk_step;
      if (cmd.clr_step) begin
        clr_cnt <= stat.clr_last ? '0 : clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      pend_addr <= addr_r;
      pend_mask <= mask;
      pend_on   <= on_r;
    end
  end

  assign idx_ok  = 32'(idx_r) < 32'(STORE_BYTES);
  assign rd_en   = cmd.walk_step || cmd.rd_issue;
  assign rd_addr = cmd.rd_issue ? ADDR_W'(idx_r) : addr_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt] <= '0;
    end else if (pend_v) begin
      mem[pend_addr] <= pend_on ? (mem_q | pend_mask) : (mem_q & ~pend_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.read_data     <= ((cmd_r == CMD_READ) && idx_ok) ? mem_q : '0;
      rsp.start_outside <= outside_r;
    end
  end

  always_comb begin
    stat.req_valid  = req.valid;
    stat.cmd        = cmd_r;
    stat.walk_empty = outside_r || (xe_r == COORD_W'(x_r)) || (ye_r == COORD_W'(y_r));
    stat.walk_last  = col_last && (page_r == plast_r);
    stat.clr_last   = clr_cnt == ADDR_W'(STORE_BYTES - 1);
    stat.out_free   = !rsp.valid || rsp.ready;
  end

endmodule

`default_nettype wire

[src/page_packed_framebuffer_fill_core.sv]
// Top level of the page packed frame buffer fill core.
// Depends on ppfb_pkg, the channel interfaces, ppfb_ctl, ppfb_dp and the defines header.
//
//   channel  dir  word
//   req      in   cmd, x_pos, y_pos, rect_width, rect_height, pixel_on, read_index
//   rsp      out  read_data, start_outside
//
// A read, or a draw that is empty or clipped away, skips the byte walk.
// A rectangle's bytes are walked one per cycle through the single read and
// single write port of the frame memory.
// A clear-all clears one store byte per cycle.
// After reset a clearing pass over all 1024 store bytes runs with req.ready low.
// A finished word waits in the rsp register; the next word is taken meanwhile.
`default_nettype none
`include "page_packed_framebuffer_fill_core_defines.svh"

module page_packed_framebuffer_fill_core (
  input  wire logic  clk,
  input  wire logic  rst,
  ppfb_req_if.sink   req,
  ppfb_rsp_if.source rsp
);
  import ppfb_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  ppfb_ctl u_ctl (
    .clk  (clk),
    .rst  (rst),
    .stat (dp_stat),
    .cmd  (ctl_cmd)
  );

  ppfb_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ctl_cmd),
    .stat (dp_stat),
    .req  (req),
    .rsp  (rsp)
  );

  `PPFB_ASSERT_SAME(a_res_slot_free, ctl_cmd.res_load, !rsp.valid || rsp.ready, "rsp busy")
  `PPFB_ASSERT_NEXT(a_one_at_a_time, (req.valid && req.ready), !req.ready, "second word taken")
  `PPFB_ASSERT_SAME(a_out_zero, rsp.valid && rsp.start_outside, rsp.read_data == '0, "nonzero")

endmodule

`default_nettype wire

[tb/sv/page_packed_framebuffer_fill_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for page_packed_framebuffer_fill_core: command words in, result words out.
// Depends on ppfb_pkg and the ppfb_req_if / ppfb_rsp_if channel interfaces of the RTL.
// A mirror of the frame store predicts every result word, which is checked in arrival order.

module page_packed_framebuffer_fill_core_tb;
  import ppfb_pkg::*;

  localparam int TIMEOUT_NS = 20_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [POS_W-1:0] rect_width;
    logic [POS_W-1:0] rect_height;
    logic             pixel_on;
    logic [IDX_W-1:0] read_index;
  } fill_word_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              start_outside;
  } fill_result_t;

  logic clk;
  logic rst = 1'b1;

  ppfb_req_if req_ch ();
  ppfb_rsp_if rsp_ch ();

  page_packed_framebuffer_fill_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [DATA_W-1:0] frame_mirror [STORE_BYTES];
  fill_word_t        cmd_word_q [$];
  fill_result_t      due_result_q [$];
  fill_word_t        on_bus;
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              hold_go = 1'b0;
  logic              rsp_hold = 1'b0;
  int                last_x = 0;
  int                last_y = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  function automatic void plot(input int col, input int row, input logic on);
    int addr;
    addr = (row / 8) * DISPLAY_WIDTH + col;
    if (col >= DISPLAY_WIDTH || row >= DISPLAY_HEIGHT || addr >= STORE_BYTES) return;
    frame_mirror[addr[ADDR_W-1:0]][row[2:0]] = on;
  endfunction

  function automatic fill_result_t frame_apply(input fill_word_t w);
    fill_result_t r;
    int           x_end;
    int           y_end;
    logic         off_screen;
    r.read_data = '0;
    r.start_outside = 1'b0;
    off_screen = (int'(w.x_pos) >= DISPLAY_WIDTH) || (int'(w.y_pos) >= DISPLAY_HEIGHT);
    case (w.cmd)
      CMD_CLEAR: begin
        foreach (frame_mirror[i]) frame_mirror[i] = '0;
      end
      CMD_PIXEL: begin
        r.start_outside = off_screen;
        if (!off_screen) plot(int'(w.x_pos), int'(w.y_pos), w.pixel_on);
      end
      CMD_FILL: begin
        r.start_outside = off_screen;
        if (!off_screen) begin
          x_end = int'(w.x_pos) + int'(w.rect_width);
          y_end = int'(w.y_pos) + int'(w.rect_height);
          if (x_end > DISPLAY_WIDTH) x_end = DISPLAY_WIDTH;
          if (y_end > DISPLAY_HEIGHT) y_end = DISPLAY_HEIGHT;
          for (int row = int'(w.y_pos); row < y_end; row++)
            for (int col = int'(w.x_pos); col < x_end; col++)
              plot(col, row, w.pixel_on);
        end
      end
      default: begin
        if (int'(w.read_index) < STORE_BYTES) r.read_data = frame_mirror[w.read_index];
      end
    endcase
    return r;
  endfunction

  function automatic fill_word_t make_word(input logic [CMD_W-1:0] cmd, input int x, input int y,
                                           input int wd, input int ht, input int on,
                                           input int idx);
    fill_word_t w;
    w.cmd = cmd;
    w.x_pos = POS_W'(x);
    w.y_pos = POS_W'(y);
    w.rect_width = POS_W'(wd);
    w.rect_height = POS_W'(ht);
    w.pixel_on = (on != 0);
    w.read_index = IDX_W'(idx);
    return w;
  endfunction

  function automatic fill_word_t random_word();
    fill_word_t w;
    int         roll;
    roll = $urandom_range(99);
    w.x_pos = POS_W'($urandom_range(255));
    w.y_pos = POS_W'($urandom_range(255));
    w.rect_width = POS_W'($urandom_range(255));
    w.rect_height = POS_W'($urandom_range(255));
    w.pixel_on = ($urandom_range(99) < 70);
    w.read_index = IDX_W'($urandom_range(1023));
    if (roll < 3) begin
      w.cmd = CMD_CLEAR;
    end else if (roll < 38) begin
      w.cmd = CMD_PIXEL;
      if ($urandom_range(99) < 88) begin
        w.x_pos = POS_W'($urandom_range(DISPLAY_WIDTH - 1));
        w.y_pos = POS_W'($urandom_range(DISPLAY_HEIGHT - 1));
      end
      last_x = int'(w.x_pos);
      last_y = int'(w.y_pos);
    end else if (roll < 60) begin
      w.cmd = CMD_FILL;
      if ($urandom_range(99) < 88) begin
        w.x_pos = POS_W'($urandom_range(DISPLAY_WIDTH - 1));
        w.y_pos = POS_W'($urandom_range(DISPLAY_HEIGHT - 1));
      end
      if ($urandom_range(99) < 88) begin
        w.rect_width = POS_W'($urandom_range(24));
        w.rect_height = POS_W'($urandom_range(20));
      end
      last_x = int'(w.x_pos);
      last_y = int'(w.y_pos);
    end else begin
      w.cmd = CMD_READ;
      if ($urandom_range(99) < 60)
        w.read_index = IDX_W'(((last_y / 8) * DISPLAY_WIDTH + last_x + $urandom_range(15)) % 1024);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) due_result_q.push_back(frame_apply(on_bus));
      if (!req_ch.valid || req_ch.ready) begin
        if (cmd_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = cmd_word_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= on_bus.cmd;
          req_ch.x_pos <= on_bus.x_pos;
          req_ch.y_pos <= on_bus.y_pos;
          req_ch.rect_width <= on_bus.rect_width;
          req_ch.rect_height <= on_bus.rect_height;
          req_ch.pixel_on <= on_bus.pixel_on;
          req_ch.read_index <= on_bus.read_index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    fill_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_result_q.size() == 0) begin
          $error("unexpected result word: read_data %0h start_outside %0b",
                 rsp_ch.read_data, rsp_ch.start_outside);
          error_count++;
        end else begin
          want = due_result_q.pop_front();
          if (rsp_ch.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, rsp_ch.read_data);
            error_count++;
          end
          if (rsp_ch.start_outside !== want.start_outside) begin
            $error("start_outside: expected %0b, actual %0b", want.start_outside,
                   rsp_ch.start_outside);
            error_count++;
          end
        end
      end
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The receiver holds off long enough for the core to fill up and stall its input.
  initial begin
    while (!hold_go) @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  task automatic drain();
    @(negedge clk);
    while (cmd_word_q.size() != 0 || req_ch.valid || due_result_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int send_idle, input int recv_stall);
    @(negedge clk);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    repeat (count) cmd_word_q.push_back(random_word());
    drain();
  endtask

  initial begin
    fill_word_t w;
    foreach (frame_mirror[i]) frame_mirror[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 0));
    cmd_word_q.push_back(make_word(CMD_PIXEL, 0, 0, 0, 0, 1, 0));
    cmd_word_q.push_back(make_word(CMD_PIXEL, 127, 63, 0, 0, 1, 0));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 0));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 1023));
    cmd_word_q.push_back(make_word(CMD_PIXEL, 128, 0, 0, 0, 1, 0));
    cmd_word_q.push_back(make_word(CMD_PIXEL, 0, 64, 0, 0, 1, 0));
    cmd_word_q.push_back(make_word(CMD_PIXEL, 255, 255, 255, 255, 1, 1023));
    cmd_word_q.push_back(make_word(CMD_FILL, 120, 60, 255, 255, 1, 0));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 1023));
    cmd_word_q.push_back(make_word(CMD_FILL, 10, 10, 0, 5, 1, 0));
    cmd_word_q.push_back(make_word(CMD_FILL, 10, 10, 5, 0, 1, 0));
    cmd_word_q.push_back(make_word(CMD_FILL, 128, 5, 4, 4, 1, 0));
    cmd_word_q.push_back(make_word(CMD_FILL, 5, 64, 4, 4, 1, 0));
    cmd_word_q.push_back(make_word(CMD_FILL, 0, 0, 255, 255, 1, 0));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 512));
    cmd_word_q.push_back(make_word(CMD_FILL, 1, 1, 3, 10, 0, 0));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 1));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 129));
    cmd_word_q.push_back(make_word(CMD_PIXEL, 127, 63, 0, 0, 0, 0));
    cmd_word_q.push_back(make_word(CMD_READ, 0, 0, 0, 0, 0, 1023));
    cmd_word_q.push_back(make_word(CMD_CLEAR, 255, 255, 255, 255, 1, 1023));
    cmd_word_q.push_back(make_word(CMD_READ, 255, 255, 255, 255, 1, 512));
    drain();

    run_phase(200, 0, 0);
    run_phase(200, 64, 0);
    run_phase(200, 0, 64);
    run_phase(200, 34, 34);

    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    while (cmd_word_q.size() < 60) begin
      w = random_word();
      if (w.cmd == CMD_READ || w.cmd == CMD_PIXEL) cmd_word_q.push_back(w);
    end
    drain();

    repeat (40) @(posedge clk);
    if (error_count == 0 && due_result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
